// ===== sv/fmcc_pkg.sv =====
// Shared types, constants and the CRC-8 byte step for the frame checker.
package fmcc_pkg;

    localparam int FRAME_LEN      = 5;
    localparam int BUFFER_LEN_DEF = 16;
    localparam int QUEUE_DEPTH    = 2;
    localparam int CHECK_INDEX    = 4;
    localparam int RUN_LEN        = 2 * FRAME_LEN;

    localparam logic [7:0] CRC_POLY   = 8'h31;
    localparam logic [7:0] CRC_INIT   = 8'hFF;
    localparam logic [7:0] CHECK_MASK = 8'h7F;

    localparam logic [7:0] HDR_FIRST_RST  = 8'hFF;
    localparam logic [7:0] HDR_SECOND_RST = 8'h02;
    localparam logic [7:0] HDR_THIRD_RST  = 8'h14;

    // configuration register indexes
    localparam logic [1:0] REG_HDR_FIRST  = 2'd0;
    localparam logic [1:0] REG_HDR_SECOND = 2'd1;
    localparam logic [1:0] REG_HDR_THIRD  = 2'd2;

    // five received bytes of a frame that passed its check
    typedef struct packed {
        logic [FRAME_LEN-1:0][7:0] bytes;
    } frame_job_t;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        logic [7:0] third;
    } header_t;

    // one byte through the CRC-8: MSB first, no reflection
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] acc;
        acc = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (acc[7])
                acc = {acc[6:0], 1'b0} ^ CRC_POLY;
            else
                acc = {acc[6:0], 1'b0};
        end
        return acc;
    endfunction

endpackage

// ===== sv/fmcc_front.sv =====
// Front end: stores received bytes, tracks write position, checks frames.
module fmcc_front
    import fmcc_pkg::*;
#(
    parameter int BUFFER_LEN = BUFFER_LEN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       q_full,
    output logic       push,
    output frame_job_t push_job
);

    localparam int POS_W = $clog2(BUFFER_LEN);

    logic [POS_W-1:0]          pos_reg;
    logic [POS_W-1:0]          pos_next;
    logic [FRAME_LEN-1:0][7:0] store_reg;
    logic [FRAME_LEN-1:0][7:0] store_next;
    logic [POS_W-1:0]          pos_base;
    logic [POS_W:0]            pos_inc;
    logic                      wrap;
    logic [7:0]                check;
    logic                      hit;
    logic                      accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        pos_base = rx_byte[7] ? '0 : pos_reg;
        pos_inc  = {1'b0, pos_base} + (POS_W+1)'(1);
        wrap     = pos_inc >= (POS_W+1)'(BUFFER_LEN);

        for (int i = 0; i < FRAME_LEN; i++) begin
            store_next[i] = (pos_base == POS_W'(i)) ? rx_byte : store_reg[i];
        end

        check = '0;
        for (int i = 0; i < CHECK_INDEX; i++) begin
            check = check ^ store_next[i];
        end
        check = check & CHECK_MASK;

        hit = !wrap && (pos_inc >= (POS_W+1)'(FRAME_LEN))
              && (check == store_next[CHECK_INDEX]);

        if (hit || wrap)
            pos_next = '0;
        else
            pos_next = pos_inc[POS_W-1:0];
    end

    assign push           = accept && hit;
    assign push_job.bytes = store_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (accept)
            pos_reg <= pos_next;
    end

    // frame bytes carry no reset; each is written before it can be checked
    always_ff @(posedge clk)
    begin
        if (accept)
            store_reg <= store_next;
    end

endmodule

// ===== sv/fmcc_queue.sv =====
// Short queue of checked frames between front and back.
module fmcc_queue
    import fmcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  frame_job_t push_job,
    input  logic       pop,
    output logic       full,
    output logic       not_empty,
    output frame_job_t head_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    frame_job_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;

    assign full      = count_reg == CNT_W'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head_job  = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            return '0;
        else
            return p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== sv/fmcc_back.sv =====
// Back end: plays out echo and converted frame, folding the CRC as it goes.
module fmcc_back
    import fmcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       not_empty,
    input  frame_job_t head_job,
    input  header_t    hdr,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       to_serial,
    output logic       last_of_run
);

    localparam int IDX_W = $clog2(RUN_LEN);

    logic [IDX_W-1:0] idx_reg;
    logic [7:0]       crc_reg;
    logic             valid_reg;
    logic [7:0]       byte_reg;
    logic             serial_reg;
    logic             last_reg;
    logic             advance;
    logic             load;
    logic [7:0]       sel_byte;
    logic [7:0]       conv3;

    assign advance = !valid_reg || !out_stall;
    assign load    = advance && not_empty;
    assign pop     = load && (idx_reg == IDX_W'(RUN_LEN - 1));
    assign conv3   = {head_job.bytes[2][0] | head_job.bytes[3][7], head_job.bytes[3][6:0]};

    always_comb
    begin
        sel_byte = crc_reg;
        if (idx_reg < IDX_W'(FRAME_LEN))
            sel_byte = head_job.bytes[idx_reg[$clog2(FRAME_LEN)-1:0]];
        else if (idx_reg == IDX_W'(FRAME_LEN))
            sel_byte = hdr.first;
        else if (idx_reg == IDX_W'(FRAME_LEN + 1))
            sel_byte = hdr.second;
        else if (idx_reg == IDX_W'(FRAME_LEN + 2))
            sel_byte = hdr.third;
        else if (idx_reg == IDX_W'(FRAME_LEN + 3))
            sel_byte = conv3;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else if (advance) begin
            valid_reg <= not_empty;
            if (load)
                idx_reg <= pop ? '0 : idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            byte_reg   <= sel_byte;
            serial_reg <= idx_reg >= IDX_W'(FRAME_LEN);
            last_reg   <= idx_reg == IDX_W'(RUN_LEN - 1);
            if (idx_reg == '0)
                crc_reg <= CRC_INIT;
            else if (idx_reg >= IDX_W'(FRAME_LEN) && idx_reg < IDX_W'(RUN_LEN - 1))
                crc_reg <= crc8_byte(crc_reg, sel_byte);
        end
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign to_serial   = serial_reg;
    assign last_of_run = last_reg;

endmodule

// ===== sv/framed_message_check_and_convert.sv =====
// Top level of the framed message checker and converter.
// Received bytes enter one per cycle on the rx channel while in_stall is low. A
// byte with bit 7 set restarts a frame; bytes land at a write position that wraps
// at BUFFER_LEN, and once five are held byte 4 is checked against the 7-bit
// XOR of bytes 0..3. A passing frame is queued (two frames deep) and the back
// end then sends ten transactions on the out channel: the five received bytes
// as an echo (to_serial = 0), then three header bytes, bit 0 of byte 2 joined
// to byte 3, and a CRC-8 (poly 0x31, init 0xFF) over those four (to_serial = 1,
// last_of_run on the tenth). Input takes one byte per cycle until the frame
// queue is full; output runs one byte per cycle while out_stall is low, so
// under a stream of valid frames the input is held back by the output byte
// sequencer. Header registers are to be written via the cfg port (index 0..2,
// others ignored) only while the block is idle; the block does not enforce it.
module framed_message_check_and_convert
    import fmcc_pkg::*;
#(
    parameter int BUFFER_LEN = BUFFER_LEN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    // received bytes
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    // emitted bytes
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       to_serial,
    output logic       last_of_run,
    // header register writes
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    header_t    hdr_reg;
    logic       q_full;
    logic       q_not_empty;
    logic       push;
    logic       pop;
    frame_job_t push_job;
    frame_job_t head_job;

    // header registers always take a write
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hdr_reg.first  <= HDR_FIRST_RST;
            hdr_reg.second <= HDR_SECOND_RST;
            hdr_reg.third  <= HDR_THIRD_RST;
        end
        else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_HDR_FIRST:  hdr_reg.first  <= cfg_data;
                REG_HDR_SECOND: hdr_reg.second <= cfg_data;
                REG_HDR_THIRD:  hdr_reg.third  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // front: store, position, check
    fmcc_front #(
        .BUFFER_LEN (BUFFER_LEN)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    // checked frames waiting for the back end
    fmcc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    // back: ten-byte run per frame, registered output
    fmcc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .not_empty   (q_not_empty),
        .head_job    (head_job),
        .hdr         (hdr_reg),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .to_serial   (to_serial),
        .last_of_run (last_of_run)
    );

endmodule

// ===== sim/framed_message_check_and_convert_tb.sv =====
// Self-checking testbench for the framed message checker and converter.
`timescale 1ns / 100ps

module framed_message_check_and_convert_tb;
    import fmcc_pkg::*;

    // cfg_index 3 maps to no register; writes to it must leave the headers alone
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam int RESET_CYCLES  = 11;
    localparam int MAX_GAP       = 18;
    localparam int SETTLE_CYCLES = 32;     // frame queue plus one ten-byte run, with margin
    localparam int CYCLE_LIMIT   = 200000;
    localparam int BUF_LEN       = BUFFER_LEN_DEF;

    // one out channel transaction as predicted
    typedef struct packed {
        logic [7:0] data;
        logic       serial;
        logic       last;
    } out_beat_t;

    // Tracks the block's frame store, write position and header registers, and
    // keeps the out transactions that each accepted rx byte is due to cause.
    class convert_scoreboard;
        logic [7:0] hdr_first;
        logic [7:0] hdr_second;
        logic [7:0] hdr_third;
        logic [7:0] held[FRAME_LEN];
        int         wr_pos;
        out_beat_t  bytes_due[$];
        int         errors;

        function new();
            hdr_first  = HDR_FIRST_RST;
            hdr_second = HDR_SECOND_RST;
            hdr_third  = HDR_THIRD_RST;
            wr_pos     = 0;
            errors     = 0;
            foreach (held[i])
                held[i] = 8'h00;
        endfunction

        function void set_header(logic [1:0] idx, logic [7:0] value);
            case (idx)
                REG_HDR_FIRST:  hdr_first  = value;
                REG_HDR_SECOND: hdr_second = value;
                REG_HDR_THIRD:  hdr_third  = value;
                default: ;
            endcase
        endfunction

        function void take_rx_byte(logic [7:0] rx);
            logic [7:0] parity;
            logic [7:0] conv[FRAME_LEN];
            logic [7:0] crc;
            int         i;
            int         k;

            if (rx[7])
                wr_pos = 0;
            // only the first five slots are ever read back
            if (wr_pos < FRAME_LEN)
                held[wr_pos] = rx;
            wr_pos = wr_pos + 1;
            // wrapping to zero skips the check on this byte
            if (wr_pos >= BUF_LEN)
                wr_pos = 0;
            if (wr_pos < FRAME_LEN)
                return;

            parity = (held[0] ^ held[1] ^ held[2] ^ held[3]) & CHECK_MASK;
            // failed check: nothing out, position is not reset
            if (parity != held[CHECK_INDEX])
                return;

            conv[0] = hdr_first;
            conv[1] = hdr_second;
            conv[2] = hdr_third;
            conv[3] = {held[2][0], 7'b0} | held[3];
            crc = CRC_INIT;
            for (i = 0; i < 4; i++)
            begin
                crc = crc ^ conv[i];
                for (k = 0; k < 8; k++)
                    crc = crc[7] ? ({crc[6:0], 1'b0} ^ CRC_POLY) : {crc[6:0], 1'b0};
            end
            conv[4] = crc;

            for (i = 0; i < FRAME_LEN; i++)
                bytes_due.push_back('{data: held[i], serial: 1'b0, last: 1'b0});
            for (i = 0; i < FRAME_LEN; i++)
                bytes_due.push_back('{data: conv[i], serial: 1'b1,
                                      last: (i == FRAME_LEN - 1)});
            wr_pos = 0;
        endfunction

        function void check_out(logic [7:0] data, logic serial, logic last);
            out_beat_t want;
            if (bytes_due.size() == 0)
            begin
                $display("%0t: out transaction with none due: %s %02h %s %0b %s %0b",
                         $time, "out_byte", data, "to_serial", serial,
                         "last_of_run", last);
                errors++;
                return;
            end
            want = bytes_due.pop_front();
            if (data !== want.data)
            begin
                $display("%0t: out_byte expected %02h actual %02h", $time, want.data, data);
                errors++;
            end
            if (serial !== want.serial)
            begin
                $display("%0t: to_serial expected %0b actual %0b", $time, want.serial, serial);
                errors++;
            end
            if (last !== want.last)
            begin
                $display("%0t: last_of_run expected %0b actual %0b", $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       to_serial;
    logic       last_of_run;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    convert_scoreboard sb;
    int                rx_count;
    int                cycle_count;
    bit                rx_quiet;      // sender runs back to back while set
    bit                out_quiet;     // receiver never stalls while set

    framed_message_check_and_convert uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .to_serial   (to_serial),
        .last_of_run (last_of_run),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Monitors sample at the rising edge, before the block's flops update.
    // The predictor advances on every accepted rx transaction and every
    // accepted out transaction is checked against the oldest one due.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && in_valid && !in_stall)
            sb.take_rx_byte(rx_byte);
        if (rst_n === 1'b1 && out_valid && !out_stall)
            sb.check_out(out_byte, to_serial, last_of_run);
    end

    // Watchdog: a hang anywhere (lost bytes, stuck handshake) ends here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("framed_message_check_and_convert regression: fail");
        $finish;
    end

    // Out side: before each transaction draw a random stall, then hold
    // stall low until a byte is taken. Quiet stretches toggle at random.
    initial
    begin
        int n;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                out_quiet = !out_quiet;
            n = out_quiet ? 0 : $urandom_range(0, MAX_GAP);
            @(negedge clk);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // One rx transaction: optional gap with valid low, then hold the byte until
    // taken. With no gap valid stays high, so it gets a single assignment.
    task automatic send_rx(input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 15) == 0)
            rx_quiet = !rx_quiet;
        gap = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (in_stall);
        rx_count++;
    endtask

    // Five bytes; the fifth is the 7-bit XOR check, spoiled when good is 0.
    task automatic send_frame(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] b3, input bit good);
        logic [7:0] chk;
        chk = (b0 ^ b1 ^ b2 ^ b3) & CHECK_MASK;
        if (!good)
            chk = (chk ^ 8'($urandom_range(1, 127))) & CHECK_MASK;
        send_rx(b0);
        send_rx(b1);
        send_rx(b2);
        send_rx(b3);
        send_rx(chk);
    endtask

    function automatic logic [7:0] low_byte();
        return 8'($urandom_range(0, 127));
    endfunction

    function automatic logic [7:0] start_byte();
        return 8'h80 | 8'($urandom_range(0, 127));
    endfunction

    // Drop rx valid, wait for every due byte, then give the block time to
    // finish any frame that fails its check before touching the registers.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_header(input logic [1:0] idx, input logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.set_header(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_headers(input logic [7:0] h0, input logic [7:0] h1,
                               input logic [7:0] h2);
        write_header(REG_HDR_FIRST, h0);
        write_header(REG_HDR_SECOND, h1);
        write_header(REG_HDR_THIRD, h2);
    endtask

    // Mostly well formed frames with random content; the rest are bad checks,
    // truncated frames, raw noise, and a failed frame followed by enough low
    // bytes to wrap the write position and land an unmarked frame at slot 0.
    task automatic run_random(input int count);
        int stop_at;
        int pick;
        int n;
        stop_at = rx_count + count;
        while (rx_count < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                send_frame(start_byte(), low_byte(), low_byte(), low_byte(), 1'b1);
            else if (pick < 70)
                send_frame(start_byte(), low_byte(), low_byte(), low_byte(), 1'b0);
            else if (pick < 78)
            begin
                send_rx(start_byte());
                n = $urandom_range(1, 3);
                repeat (n) send_rx(low_byte());
            end
            else if (pick < 88)
            begin
                n = $urandom_range(1, 4);
                repeat (n) send_rx(8'($urandom_range(0, 255)));
            end
            else
            begin
                send_frame(start_byte(), low_byte(), low_byte(), low_byte(), 1'b0);
                repeat (BUF_LEN - FRAME_LEN) send_rx(low_byte());
                send_frame(low_byte(), low_byte(), low_byte(), low_byte(), 1'b1);
            end
        end
    endtask

    initial
    begin
        sb        = new();
        rx_count  = 0;
        rx_quiet  = 1'b0;
        out_quiet = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        rx_byte   = 8'h00;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_HDR_FIRST;
        cfg_data  = 8'h00;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, reset headers.
        // all-zero frame with no start mark, straight out of reset
        send_frame(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
        // all-ones extremes, byte 2 bit 0 set
        send_frame(8'hFF, 8'h7F, 8'h7F, 8'h7F, 1'b1);
        // bad check, then a byte past the frame re-checks and fails again
        send_frame(8'h80, 8'h01, 8'h02, 8'h03, 1'b0);
        send_rx(8'h00);
        // start mark pulls the position back to 0
        send_frame(8'h81, 8'h10, 8'h21, 8'h30, 1'b1);
        // truncated frame cut short by a new start
        send_rx(8'hC5);
        send_frame(8'hAA, 8'h55, 8'h00, 8'h7E, 1'b1);
        run_random(20);
        settle();

        // Headers all zero; a write to the unused index must change nothing.
        set_headers(8'h00, 8'h00, 8'h00);
        write_header(REG_UNUSED, 8'h5A);
        run_random(50);
        settle();

        set_headers(8'hFF, 8'hFF, 8'hFF);
        run_random(50);
        settle();

        set_headers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
        run_random(50);
        settle();

        set_headers(HDR_FIRST_RST, HDR_SECOND_RST, HDR_THIRD_RST);
        run_random(45);
        settle();

        if (sb.errors == 0)
            $display("framed_message_check_and_convert regression: pass");
        else
            $display("framed_message_check_and_convert regression: fail");
        $finish;
    end

endmodule
